/* src/twcs_pkg.sv */
package twcs_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int DEV_W = 3;
  localparam int CNT_W = 4;

  localparam logic [31:0] TOTAL_RST = 32'd200000000;
  localparam logic [27:0] BASE_RST = 28'd1000000;
  localparam logic [27:0] MAXC_RST = 28'd8000000;
  localparam logic [16:0] ALPHA_RST = 17'd19661;
  localparam logic [3:0] ACTIVE_RST = 4'd1;
  localparam logic [47:0] INIT_TP_RST = 48'd1000000;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [2:0] REG_TOTAL = 3'd0;
  localparam logic [2:0] REG_BASE = 3'd1;
  localparam logic [2:0] REG_MAXC = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;
  localparam logic [2:0] REG_ACTIVE = 3'd4;
  localparam logic [2:0] REG_INIT_TP = 3'd5;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // divider: numerator up to 80 bits, divisor up to 51 bits
  localparam int NUM_W = 80;
  localparam int DEN_W = 52;
  localparam int QCNT_W = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_MUL2,
    ST_DIV,
    ST_GRANT,
    ST_SMUL,
    ST_SDIV,
    ST_EMA1,
    ST_EMA2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/throughput_weighted_chunk_scheduler_unit.sv */
// Chunk scheduler. One beat in, one beat out, one item at a time. A request
// sums the active estimates (one per cycle, up to 8), forms remaining*estimate
// in two passes through one 32x24 multiplier, then runs an 80-step bit-serial
// divider; out_valid rises after the divide, through ST_GRANT and ST_OUT. With
// a zero estimate sum the divide is skipped. A report runs the sample divide
// on the same divider and two multiply steps. Bad devices, requests with no
// work left and reports with zero elapsed time go straight to ST_OUT, which
// sets out_valid. in_ready is low while an item is in work or its result
// waits. Writing initial_throughput reloads every estimate.
module throughput_weighted_chunk_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [2:0]  device,
  input  logic [31:0] elapsed_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] start_index,
  output logic [27:0] chunk_length,
  output logic        done_res,
  output logic        bad_device,
  output logic [47:0] throughput_out
);
  import twcs_pkg::*;

  logic [31:0] total_items;
  logic [27:0] chunk_floor, chunk_cap;
  logic [16:0] alpha_q16;
  logic [3:0] active_devices;
  logic [31:0] next_start;
  logic [47:0] est [MAX_DEVICES];
  logic [27:0] last_granted [MAX_DEVICES];

  state_t state, state_next;
  logic [DEV_W-1:0] dev;
  logic [31:0] elapsed;
  logic [31:0] remaining;
  logic [50:0] sum;
  logic [CNT_W-1:0] idx;
  logic [63:0] prod;
  logic [CNT_W-1:0] act;
  logic dev_bad, no_work;
  logic [47:0] est_dev;
  logic [55:0] mul_p;

  div_req_t dreq;
  div_stat_t dstat;
  logic [NUM_W-1:0] quot;
  logic [DEN_W-1:0] rem;

  twcs_div u_div (.clk(clk), .rst(rst), .req(dreq), .stat(dstat), .quot(quot), .rem(rem));

  assign act = (active_devices > CNT_W'(MAX_DEVICES)) ? CNT_W'(MAX_DEVICES) : active_devices;
  assign dev_bad = {1'b0, device} >= act;
  assign no_work = next_start >= total_items;
  assign est_dev = est[dev];
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign mul_p = remaining * ((state == ST_MUL) ? est_dev[23:0] : est_dev[47:24]);

  // chunk decision
  logic [NUM_W-1:0] q_round;
  logic [NUM_W-1:0] chunk_w;
  logic [27:0] chunk;
  always_comb begin
    q_round = quot + NUM_W'({rem, 1'b0} >= {1'b0, sum});
    chunk_w = NUM_W'(chunk_floor);
    if (sum != '0 && q_round > chunk_w) chunk_w = q_round;
    if (chunk_w > NUM_W'(remaining)) chunk_w = NUM_W'(remaining);
    if (chunk_w > NUM_W'(chunk_cap)) chunk_w = NUM_W'(chunk_cap);
    chunk = chunk_w[27:0];
  end

  logic [16:0] a_eff;
  logic [47:0] sample;
  assign a_eff = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
  assign sample = (quot > NUM_W'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : quot[47:0];

  always_comb begin
    state_next = state;
    dreq = '0;
    case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        if (dev_bad) state_next = ST_OUT;
        else if (opcode == OP_REQUEST) state_next = no_work ? ST_OUT : ST_SUM;
        else state_next = (elapsed_us == '0) ? ST_OUT : ST_SMUL;
      end
      ST_SUM: if (idx == act - 1'b1) state_next = ST_MUL;
      ST_MUL: state_next = ST_MUL2;
      ST_MUL2: begin
        dreq.start = (sum != '0);
        dreq.num = {mul_p, 24'd0} + NUM_W'(prod);
        dreq.den = DEN_W'(sum);
        state_next = (sum != '0) ? ST_DIV : ST_GRANT;
      end
      ST_DIV: if (dstat.done) state_next = ST_GRANT;
      ST_GRANT: state_next = ST_OUT;
      ST_SMUL: begin
        dreq.start = 1'b1;
        dreq.num = NUM_W'(last_granted[dev]) * NUM_W'(US_PER_S);
        dreq.den = DEN_W'(elapsed);
        state_next = ST_SDIV;
      end
      ST_SDIV: if (dstat.done) state_next = ST_EMA1;
      ST_EMA1: state_next = ST_EMA2;
      ST_EMA2: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [64:0] ema_a, ema_b;
  logic [64:0] ema_sum;
  assign ema_a = 65'(a_eff) * 65'(sample);
  assign ema_b = 65'(ALPHA_ONE - a_eff) * 65'(est_dev);
  assign ema_sum = {1'b0, prod} + ema_b + 65'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      total_items <= TOTAL_RST;
      chunk_floor <= BASE_RST;
      chunk_cap <= MAXC_RST;
      alpha_q16 <= ALPHA_RST;
      active_devices <= ACTIVE_RST;
      next_start <= '0;
      for (int i = 0; i < MAX_DEVICES; i++) begin
        est[i] <= INIT_TP_RST;
        last_granted[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL: total_items <= cfg_data[31:0];
          REG_BASE: chunk_floor <= cfg_data[27:0];
          REG_MAXC: chunk_cap <= cfg_data[27:0];
          REG_ALPHA: alpha_q16 <= cfg_data[16:0];
          REG_ACTIVE: active_devices <= cfg_data[3:0];
          REG_INIT_TP: for (int i = 0; i < MAX_DEVICES; i++) est[i] <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_GRANT) begin
        next_start <= next_start + 32'(chunk);
        last_granted[dev] <= chunk;
      end
      if (state == ST_EMA2) est[dev] <= ema_sum[63:16];
      if (state == ST_OUT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        dev <= device;
        elapsed <= elapsed_us;
        remaining <= total_items - next_start;
        sum <= '0;
        idx <= '0;
        start_index <= (!dev_bad && opcode == OP_REQUEST && no_work) ? next_start : '0;
        chunk_length <= '0;
        done_res <= !dev_bad && opcode == OP_REQUEST && no_work;
        bad_device <= dev_bad;
        throughput_out <= dev_bad ? '0 : est[device];
      end
      ST_SUM: begin
        sum <= sum + 51'(est[idx[DEV_W-1:0]]);
        idx <= idx + 1'b1;
      end
      ST_MUL: prod <= {8'd0, mul_p};
      ST_GRANT: begin
        start_index <= next_start;
        chunk_length <= chunk;
      end
      ST_EMA1: prod <= ema_a[63:0];
      ST_EMA2: throughput_out <= ema_sum[63:16];
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_device) |-> (chunk_length == '0 && throughput_out == '0))
    else $error("bad device result not clear");
  a_done_no_chunk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (chunk_length == '0)) else $error("done with chunk");
`endif

endmodule

/* src/twcs_div.sv */
module twcs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  twcs_pkg::div_req_t         req,
  output twcs_pkg::div_stat_t        stat,
  output logic [twcs_pkg::NUM_W-1:0] quot,
  output logic [twcs_pkg::DEN_W-1:0] rem
);
  import twcs_pkg::*;

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0] rsh;
  logic [QCNT_W-1:0] cnt;
  logic busy;
  logic done;

  assign rsh = {rem, num[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !req.start && busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= QCNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
      quot <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (rsh >= {1'b0, den}) begin
        rem <= DEN_W'(rsh - {1'b0, den});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rsh[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
